@@ hw/rtl/small_vm_instruction_execute_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the small VM execute core
// Concurrent assertion wrappers clocked on clk; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef SMALL_VM_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`define SMALL_VM_INSTRUCTION_EXECUTE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVM_ASSERT(lbl, prop, msg)
`define SVM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/svm_pkg.sv @@
// ---------------------------------------------------------------------------
// Small VM package
// Sizes, opcodes, result codes and the data memory request word.
// ---------------------------------------------------------------------------
package svm_pkg;

  localparam int MEM_DEPTH = 1024;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int WORD_W    = 24;
  localparam int INSTR_W   = 48;
  localparam int REG_N     = 8;
  localparam int REG_AW    = 3;
  localparam int TGT_W     = 10;

  typedef logic [MEM_AW-1:0]  addr_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WORD_W:0]    cmp_t;
  typedef logic [INSTR_W-1:0] instr_t;
  typedef logic [REG_AW-1:0]  reg_idx_t;
  typedef logic [TGT_W-1:0]   tgt_t;

  localparam cmp_t MEM_DEPTH_CMP = cmp_t'(MEM_DEPTH);

  localparam logic [7:0] OP_LOAD_CONST = 8'd195;
  localparam logic [7:0] OP_MEM_READ   = 8'd83;
  localparam logic [7:0] OP_MEM_WRITE  = 8'd53;
  localparam logic [7:0] OP_OR         = 8'd74;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_OP = 2'd1;
  localparam logic [1:0] ST_OOB    = 2'd2;

  localparam logic [1:0] WK_NONE = 2'd0;
  localparam logic [1:0] WK_REG  = 2'd1;
  localparam logic [1:0] WK_MEM  = 2'd2;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/svm_instr_if.sv @@
// ---------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one instruction word.
// ---------------------------------------------------------------------------
interface svm_instr_if;
  logic            valid;
  logic            ready;
  svm_pkg::instr_t instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

@@ hw/rtl/svm_result_if.sv @@
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one execution result word.
// ---------------------------------------------------------------------------
interface svm_result_if;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [1:0]    write_kind;
  svm_pkg::tgt_t target_index;
  svm_pkg::word_t write_value;

  modport source (output valid, output status, output write_kind, output target_index,
                  output write_value, input ready);
  modport sink (input valid, input status, input write_kind, input target_index,
                input write_value, output ready);
endinterface

@@ hw/rtl/svm_dmem.sv @@
// ---------------------------------------------------------------------------
// Small VM data memory
// One write port, one registered read port, and a clearing pass after reset.
// ---------------------------------------------------------------------------
module svm_dmem (
  input  logic              clk,
  input  logic              rst_n,
  input  svm_pkg::mem_req_t req,
  output svm_pkg::word_t    rdata,
  output logic              busy
);

  svm_pkg::word_t mem [svm_pkg::MEM_DEPTH];
  svm_pkg::word_t rdata_r;
  svm_pkg::addr_t clr_cnt_r;
  logic           clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == svm_pkg::addr_t'(svm_pkg::MEM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

@@ hw/rtl/small_vm_instruction_execute_core.sv @@
// ---------------------------------------------------------------------------
// Small VM instruction execute core
// Executes 48-bit instructions against eight registers and a data memory.
// ---------------------------------------------------------------------------
// After reset the core clears its data memory, all MEM_DEPTH words (1024 as
// configured), one word per cycle, and accepts no instruction during that
// pass. From then on it accepts one instruction word per cycle while the
// result side does not stall, and returns one result word per instruction,
// in order. The pipeline has an input register, a stage that waits on the
// single synchronous read port of the data memory, and the result register.
// Register and memory writes made by the instruction ahead are forwarded,
// so dependent instructions may follow each other in consecutive cycles.
`include "small_vm_instruction_execute_core_macros.svh"

module small_vm_instruction_execute_core (
  input  logic         clk,
  input  logic         rst_n,
  svm_instr_if.sink    in_chan,
  svm_result_if.source out_chan
);

  // Input stage.
  logic              a_valid_r;
  svm_pkg::instr_t   a_instr_r;

  // Memory stage.
  logic              b_valid_r;
  logic [1:0]        b_status_r;
  logic [1:0]        b_kind_r;
  svm_pkg::addr_t    b_tgt_r;
  svm_pkg::word_t    b_rval_r;
  logic              b_ormem_r;
  logic              b_fwd_r;
  svm_pkg::word_t    b_fwd_data_r;

  // Result register.
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [1:0]        out_kind_r;
  svm_pkg::tgt_t     out_tgt_r;
  svm_pkg::word_t    out_value_r;

  svm_pkg::word_t    rf_r [svm_pkg::REG_N];
  svm_pkg::word_t    rf_view [svm_pkg::REG_N];

  logic              out_free, b_adv, b_free, a_adv, a_free, in_acc;
  logic              mem_busy;
  svm_pkg::word_t    mem_rdata, b_memd, b_val;
  logic              b_wr_reg, b_wr_mem;
  svm_pkg::mem_req_t mem_req;

  logic [7:0]        op;
  svm_pkg::reg_idx_t rb;
  svm_pkg::cmp_t     s_addr;
  logic [1:0]        s_status, s_kind;
  svm_pkg::addr_t    s_tgt, s_raddr;
  svm_pkg::word_t    s_rval;
  logic              s_ormem, s_re, s_fwd;

  assign out_free = !out_valid_r || out_chan.ready;
  assign b_adv    = b_valid_r && out_free;
  assign b_free   = !b_valid_r || b_adv;
  assign a_adv    = a_valid_r && b_free;
  assign a_free   = !a_valid_r || a_adv;
  assign in_chan.ready = a_free && !mem_busy;
  assign in_acc   = in_chan.valid && in_chan.ready;

  assign b_memd   = b_fwd_r ? b_fwd_data_r : mem_rdata;
  assign b_val    = b_rval_r | (b_ormem_r ? b_memd : '0);
  assign b_wr_reg = b_adv && (b_kind_r == svm_pkg::WK_REG);
  assign b_wr_mem = b_adv && (b_kind_r == svm_pkg::WK_MEM);

  always_comb begin
    for (int i = 0; i < svm_pkg::REG_N; i++) begin
      if (b_wr_reg && (b_tgt_r[svm_pkg::REG_AW-1:0] == svm_pkg::reg_idx_t'(i))) begin
        rf_view[i] = b_val;
      end else begin
        rf_view[i] = rf_r[i];
      end
    end
  end

  assign op = a_instr_r[7:0];
  assign rb = a_instr_r[10:8];

  always_comb begin
    s_status = svm_pkg::ST_OK;
    s_kind   = svm_pkg::WK_NONE;
    s_tgt    = '0;
    s_rval   = '0;
    s_ormem  = 1'b0;
    s_re     = 1'b0;
    s_raddr  = '0;
    s_addr   = '0;
    case (op)
      svm_pkg::OP_LOAD_CONST: begin
        s_kind = svm_pkg::WK_REG;
        s_tgt  = svm_pkg::addr_t'(rb);
        s_rval = a_instr_r[34:11];
      end
      svm_pkg::OP_MEM_READ: begin
        s_addr = svm_pkg::cmp_t'(rf_view[rb]);
        if (s_addr >= svm_pkg::MEM_DEPTH_CMP) begin
          s_status = svm_pkg::ST_OOB;
        end else begin
          s_kind  = svm_pkg::WK_REG;
          s_tgt   = svm_pkg::addr_t'(a_instr_r[13:11]);
          s_ormem = 1'b1;
          s_re    = 1'b1;
          s_raddr = s_addr[svm_pkg::MEM_AW-1:0];
        end
      end
      svm_pkg::OP_MEM_WRITE: begin
        s_addr = svm_pkg::cmp_t'(rf_view[a_instr_r[22:20]])
               + svm_pkg::cmp_t'(a_instr_r[19:11]);
        if (s_addr >= svm_pkg::MEM_DEPTH_CMP) begin
          s_status = svm_pkg::ST_OOB;
        end else begin
          s_kind = svm_pkg::WK_MEM;
          s_tgt  = s_addr[svm_pkg::MEM_AW-1:0];
          s_rval = rf_view[rb];
        end
      end
      svm_pkg::OP_OR: begin
        s_addr = svm_pkg::cmp_t'(a_instr_r[31:11]);
        if (s_addr >= svm_pkg::MEM_DEPTH_CMP) begin
          s_status = svm_pkg::ST_OOB;
        end else begin
          s_kind  = svm_pkg::WK_REG;
          s_tgt   = svm_pkg::addr_t'(rb);
          s_rval  = rf_view[a_instr_r[40:38]];
          s_ormem = 1'b1;
          s_re    = 1'b1;
          s_raddr = s_addr[svm_pkg::MEM_AW-1:0];
        end
      end
      default: begin
        s_status = svm_pkg::ST_BAD_OP;
      end
    endcase
  end

  // The memory reads old data when the instruction ahead writes the same
  // word in the same cycle, so that write is captured alongside the read.
  assign s_fwd = s_re && b_wr_mem && (b_tgt_r == s_raddr);

  always_comb begin
    mem_req.we    = b_wr_mem;
    mem_req.waddr = b_tgt_r;
    mem_req.wdata = b_val;
    mem_req.re    = a_adv && s_re;
    mem_req.raddr = s_raddr;
  end

  svm_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < svm_pkg::REG_N; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        b_valid_r <= 1'b1;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (b_wr_reg) begin
        rf_r[b_tgt_r[svm_pkg::REG_AW-1:0]] <= b_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_instr_r <= in_chan.instr_word;
    end
    if (a_adv) begin
      b_status_r   <= s_status;
      b_kind_r     <= s_kind;
      b_tgt_r      <= s_tgt;
      b_rval_r     <= s_rval;
      b_ormem_r    <= s_ormem;
      b_fwd_r      <= s_fwd;
      b_fwd_data_r <= b_val;
    end
    if (b_adv) begin
      out_status_r <= b_status_r;
      out_kind_r   <= b_kind_r;
      out_tgt_r    <= svm_pkg::tgt_t'(b_tgt_r);
      out_value_r  <= b_val;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.write_kind   = out_kind_r;
  assign out_chan.target_index = out_tgt_r;
  assign out_chan.write_value  = out_value_r;

  `SVM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !a_valid_r && !b_valid_r && !out_valid_r, "pipeline not empty after reset")
  `SVM_ASSERT(a_clear_idle, mem_busy |-> !a_valid_r && !b_valid_r && !out_valid_r, "instruction in flight during memory clear")
  `SVM_ASSERT(a_fault_quiet, out_valid_r && out_status_r != svm_pkg::ST_OK |-> out_kind_r == svm_pkg::WK_NONE && out_tgt_r == '0 && out_value_r == '0, "faulted result reports a write")
  `SVM_ASSERT(a_fwd_on_read, b_valid_r && b_fwd_r |-> b_ormem_r, "memory bypass set without a read")
  `SVM_ASSERT(a_stall_holds, b_valid_r && !out_free |=> b_valid_r && $stable(b_tgt_r) && $stable(b_kind_r), "memory stage lost during stall")

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the small VM instruction execute core
// Drives instructions through the valid/ready input channel, predicts result
// words from a model of the register file and data memory or the table, and
// compares them in order. A short directed table comes first, then three
// phases of random programs with varying back pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS        = 650;
  localparam int RESULT_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES        = 10;

  localparam logic [7:0] OP_UNUSED_LOW  = 8'h00;
  localparam logic [7:0] OP_UNUSED_HIGH = 8'hFF;
  localparam logic [7:0] OP_UNUSED_NEAR = 8'd54;

  localparam svm_pkg::instr_t LOAD_SPARE  = 48'hFFF8_0000_0000;
  localparam svm_pkg::instr_t READ_SPARE  = 48'hFFFF_FFFF_C000;
  localparam svm_pkg::instr_t WRITE_SPARE = 48'hFFFF_FF80_0000;
  localparam svm_pkg::instr_t OR_SPARE    = 48'hFE3F_0000_0000;

  typedef struct packed {
    logic [1:0]     status;
    logic [1:0]     write_kind;
    svm_pkg::tgt_t  target_index;
    svm_pkg::word_t write_value;
  } exec_result_t;

  typedef struct packed {
    logic         known;
    exec_result_t res;
  } typed_answer_t;

  typedef struct packed {
    svm_pkg::instr_t word;
    logic            known;
    exec_result_t    res;
  } directed_case_t;

  logic clk = 1'b0;
  logic rst_n;

  svm_instr_if  in_chan();
  svm_result_if out_chan();

  small_vm_instruction_execute_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #10 clk = ~clk;

  svm_pkg::word_t arch_regs [svm_pkg::REG_N];
  svm_pkg::word_t arch_mem [svm_pkg::MEM_DEPTH];
  exec_result_t   pending_results[$];
  typed_answer_t  typed_answers[$];
  directed_case_t directed_cases[$];

  int error_count    = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_reg_writes   = 0;
  int n_mem_writes   = 0;
  int n_oob          = 0;
  int n_bad_op       = 0;
  int src_idle_pct   = 0;
  int sink_idle_pct  = 0;
  int stall_requests = 0;

  function automatic svm_pkg::instr_t enc_load(svm_pkg::reg_idx_t b, svm_pkg::word_t c);
    return {13'd0, c, b, svm_pkg::OP_LOAD_CONST};
  endfunction

  function automatic svm_pkg::instr_t enc_read(svm_pkg::reg_idx_t b, svm_pkg::reg_idx_t c);
    return {34'd0, c, b, svm_pkg::OP_MEM_READ};
  endfunction

  function automatic svm_pkg::instr_t enc_write(svm_pkg::reg_idx_t b, logic [8:0] off,
                                                svm_pkg::reg_idx_t d);
    return {25'd0, d, off, b, svm_pkg::OP_MEM_WRITE};
  endfunction

  function automatic svm_pkg::instr_t enc_or(svm_pkg::reg_idx_t b, logic [20:0] c,
                                             svm_pkg::reg_idx_t d);
    return {7'd0, d, 6'd0, c, b, svm_pkg::OP_OR};
  endfunction

  // Updates the architectural state and returns the result word it implies.
  function automatic exec_result_t execute_instr(svm_pkg::instr_t w);
    exec_result_t      r;
    svm_pkg::reg_idx_t rb;
    svm_pkg::reg_idx_t rx;
    svm_pkg::word_t    v;
    logic [24:0]       waddr;
    logic [20:0]       c21;
    r  = '0;
    rb = w[10:8];
    case (w[7:0])
      svm_pkg::OP_LOAD_CONST: begin
        v              = w[34:11];
        arch_regs[rb]  = v;
        r.write_kind   = svm_pkg::WK_REG;
        r.target_index = svm_pkg::tgt_t'(rb);
        r.write_value  = v;
      end
      svm_pkg::OP_MEM_READ: begin
        if (arch_regs[rb] >= svm_pkg::MEM_DEPTH) begin
          r.status = svm_pkg::ST_OOB;
        end else begin
          rx             = w[13:11];
          v              = arch_mem[arch_regs[rb][svm_pkg::MEM_AW-1:0]];
          arch_regs[rx]  = v;
          r.write_kind   = svm_pkg::WK_REG;
          r.target_index = svm_pkg::tgt_t'(rx);
          r.write_value  = v;
        end
      end
      svm_pkg::OP_MEM_WRITE: begin
        rx    = w[22:20];
        waddr = {1'b0, arch_regs[rx]} + 25'(w[19:11]);
        if (waddr >= svm_pkg::MEM_DEPTH) begin
          r.status = svm_pkg::ST_OOB;
        end else begin
          v                                    = arch_regs[rb];
          arch_mem[waddr[svm_pkg::MEM_AW-1:0]] = v;
          r.write_kind                         = svm_pkg::WK_MEM;
          r.target_index = svm_pkg::tgt_t'(waddr[svm_pkg::MEM_AW-1:0]);
          r.write_value                        = v;
        end
      end
      svm_pkg::OP_OR: begin
        c21 = w[31:11];
        if (c21 >= svm_pkg::MEM_DEPTH) begin
          r.status = svm_pkg::ST_OOB;
        end else begin
          rx             = w[40:38];
          v              = arch_regs[rx] | arch_mem[c21[svm_pkg::MEM_AW-1:0]];
          arch_regs[rb]  = v;
          r.write_kind   = svm_pkg::WK_REG;
          r.target_index = svm_pkg::tgt_t'(rb);
          r.write_value  = v;
        end
      end
      default: r.status = svm_pkg::ST_BAD_OP;
    endcase
    return r;
  endfunction

  // Addresses cluster in a small window so reads often hit recent writes.
  function automatic svm_pkg::word_t pick_addr();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return svm_pkg::word_t'($urandom_range(31));
    if (sel < 85) return svm_pkg::word_t'($urandom_range(svm_pkg::MEM_DEPTH - 1));
    if (sel < 95) begin
      return svm_pkg::word_t'($urandom_range(svm_pkg::MEM_DEPTH + 64,
                                             svm_pkg::MEM_DEPTH - 32));
    end
    return svm_pkg::word_t'($urandom);
  endfunction

  function automatic svm_pkg::instr_t random_instr();
    svm_pkg::instr_t noise;
    logic [7:0]      opc;
    logic [8:0]      off;
    svm_pkg::word_t  a;
    int              pick;
    noise = svm_pkg::instr_t'({$urandom, $urandom});
    pick  = $urandom_range(99);
    if (pick < 25) begin
      a = ($urandom_range(99) < 60) ? pick_addr() : svm_pkg::word_t'($urandom);
      return enc_load(svm_pkg::reg_idx_t'($urandom), a) | (noise & LOAD_SPARE);
    end
    if (pick < 50)
      return enc_read(svm_pkg::reg_idx_t'($urandom), svm_pkg::reg_idx_t'($urandom))
             | (noise & READ_SPARE);
    if (pick < 72) begin
      off = ($urandom_range(1) != 0) ? 9'($urandom_range(15)) : 9'($urandom);
      return enc_write(svm_pkg::reg_idx_t'($urandom), off, svm_pkg::reg_idx_t'($urandom))
             | (noise & WRITE_SPARE);
    end
    if (pick < 92) begin
      a = pick_addr();
      return enc_or(svm_pkg::reg_idx_t'($urandom), a[20:0], svm_pkg::reg_idx_t'($urandom))
             | (noise & OR_SPARE);
    end
    do opc = 8'($urandom);
    while (opc == svm_pkg::OP_LOAD_CONST || opc == svm_pkg::OP_MEM_READ ||
           opc == svm_pkg::OP_MEM_WRITE || opc == svm_pkg::OP_OR);
    return {noise[47:8], opc};
  endfunction

  task automatic add_case(svm_pkg::instr_t w, logic known, logic [1:0] st, logic [1:0] wk,
                          svm_pkg::tgt_t tgt, svm_pkg::word_t val);
    directed_case_t dc;
    dc.word = w;
    dc.known = known;
    dc.res = {st, wk, tgt, val};
    directed_cases.push_back(dc);
  endtask

  task automatic send_instr(svm_pkg::instr_t w, logic known, exec_result_t res);
    typed_answer_t ans;
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    ans.known = known;
    ans.res   = res;
    typed_answers.push_back(ans);
    in_chan.valid      <= 1'b1;
    in_chan.instr_word <= w;
    do @(posedge clk); while (!in_chan.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (typed_answers.size() != 0 || pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    exec_result_t  want;
    exec_result_t  got;
    typed_answer_t ans;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = {out_chan.status, out_chan.write_kind, out_chan.target_index,
               out_chan.write_value};
        if (pending_results.size() == 0) begin
          $error("Result word 0x%0h arrived with no instruction outstanding", got);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("write_kind", 32'(want.write_kind), 32'(got.write_kind));
          check_field("target_index", 32'(want.target_index), 32'(got.target_index));
          check_field("write_value", 32'(want.write_value), 32'(got.write_value));
          n_checked++;
          if (want.status == svm_pkg::ST_OOB) n_oob++;
          if (want.status == svm_pkg::ST_BAD_OP) n_bad_op++;
          if (want.write_kind == svm_pkg::WK_REG) n_reg_writes++;
          if (want.write_kind == svm_pkg::WK_MEM) n_mem_writes++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        want = execute_instr(in_chan.instr_word);
        if (typed_answers.size() == 0) begin
          $error("Instruction word accepted that was never offered");
          error_count++;
        end else begin
          ans = typed_answers.pop_front();
          if (ans.known) want = ans.res;
        end
        pending_results.push_back(want);
      end
    end
  end

  initial begin : result_sink
    int stall_served;
    int stall_left;
    stall_served = 0;
    stall_left   = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        stall_left   = RESULT_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("small_vm_instruction_execute_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.instr_word = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;

    add_case(enc_read(3'd0, 3'd1) | READ_SPARE, 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd1, 24'd0);
    add_case(enc_load(3'd7, 24'hFFFFFF) | LOAD_SPARE, 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd7, 24'hFFFFFF);
    add_case(enc_load(3'd0, 24'd0), 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd0, 24'd0);
    add_case({40'hFF_FFFF_FFFF, OP_UNUSED_LOW}, 1'b1,
             svm_pkg::ST_BAD_OP, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case({40'd0, OP_UNUSED_HIGH}, 1'b1,
             svm_pkg::ST_BAD_OP, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case({40'h12_3456_789A, OP_UNUSED_NEAR}, 1'b1,
             svm_pkg::ST_BAD_OP, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_read(3'd7, 3'd2) | READ_SPARE, 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_load(3'd1, 24'd1023), 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd1, 24'd1023);
    add_case(enc_write(3'd7, 9'd0, 3'd1), 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_MEM, 10'd1023, 24'hFFFFFF);
    add_case(enc_write(3'd7, 9'd1, 3'd1), 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_write(3'd7, 9'h1FF, 3'd7) | WRITE_SPARE, 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_read(3'd1, 3'd2), 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd2, 24'hFFFFFF);
    add_case(enc_or(3'd3, 21'd1023, 3'd0) | OR_SPARE, 1'b1,
             svm_pkg::ST_OK, svm_pkg::WK_REG, 10'd3, 24'hFFFFFF);
    add_case(enc_or(3'd3, 21'd1024, 3'd0), 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_or(3'd3, 21'h1FFFFF, 3'd7) | OR_SPARE, 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_write(3'd2, 9'h1FF, 3'd0), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_load(3'd4, 24'd512), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_write(3'd4, 9'h1FF, 3'd4), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_read(3'd4, 3'd5), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_load(3'd6, 24'd511), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_read(3'd6, 3'd6), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_or(3'd0, 21'd1023, 3'd4), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_load(3'd5, 24'd1024), 1'b0,
             svm_pkg::ST_OK, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_read(3'd5, 3'd0), 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);
    add_case(enc_write(3'd0, 9'd0, 3'd5), 1'b1,
             svm_pkg::ST_OOB, svm_pkg::WK_NONE, 10'd0, 24'd0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle_pct  = 29;
    sink_idle_pct = 66;
    foreach (directed_cases[i])
      send_instr(directed_cases[i].word, directed_cases[i].known, directed_cases[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct  = 66;
        sink_idle_pct = 29;
      end else if (ph == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_requests++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) send_instr(random_instr(), 1'b0, '0);
      if (ph == 0) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Executed %0d instructions and checked %0d results: %0d register writes,",
             n_sent, n_checked, n_reg_writes);
    $display("%0d memory writes, %0d out-of-range rejects and %0d unknown opcodes, %s",
             n_mem_writes, n_oob, n_bad_op, "under random and long result stalls.");
    if (error_count == 0) begin
      $display("small_vm_instruction_execute_core test passed");
    end else begin
      $display("small_vm_instruction_execute_core test failed");
    end
    $finish;
  end
endmodule
